// File: rtl/odll_pkg.sv
// Shared types and constants for the ordered doubly linked list core.
package odll_pkg;

  localparam int unsigned POOL_SIZE = 64;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned HND_W     = $clog2(POOL_SIZE + 1);
  localparam logic [HND_W-1:0] END_H = HND_W'(POOL_SIZE);

  typedef logic [2:0]       req_t;
  typedef logic [1:0]       stat_t;
  typedef logic [HND_W-1:0] hnd_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam req_t REQ_INS_ORD = 3'd0;
  localparam req_t REQ_INS_HND = 3'd1;
  localparam req_t REQ_INS_KEY = 3'd2;
  localparam req_t REQ_DEL_HND = 3'd3;
  localparam req_t REQ_DEL_KEY = 3'd4;
  localparam req_t REQ_FIND    = 3'd5;
  localparam req_t REQ_CLEAR   = 3'd6;
  localparam req_t REQ_READ    = 3'd7;

  localparam stat_t ST_OK       = 2'd0;
  localparam stat_t ST_NOTFOUND = 2'd1;
  localparam stat_t ST_FULL     = 2'd2;
  localparam stat_t ST_BADHND   = 2'd3;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture request, start cursor at the first node
    CMD_RD_CUR,    // issue a read of the cursor node
    CMD_STEP,      // move cursor to its next link
    CMD_SEL_HND,   // cursor := request handle
    CMD_SEL_PRE,   // predecessor := prev of cursor (or last node)
    CMD_WR_NEW,    // write key and links of the new node
    CMD_WR_PNEXT,  // patch next link of predecessor
    CMD_WR_SPREV,  // patch prev link of successor
    CMD_UNL_P,     // delete: patch predecessor next
    CMD_UNL_X,     // delete: patch successor prev and clear valid
    CMD_CLEAR,     // clear the valid map and the list head
    CMD_REPORT     // build the result from the cursor node
  } cmd_e;

  typedef struct packed {
    cmd_e  cmd;
    stat_t status;
    logic  use_node;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_node;   // cursor names a valid node
    logic key_eq;     // cursor key equals search key
    logic key_gt;     // cursor key greater than request key
    logic hnd_ok;     // request handle names a valid node
    logic hnd_end;    // request handle is the end marker
    logic full;       // no free slot
    req_t req;
  } dp_stat_t;

endpackage

// File: rtl/odll_datapath.sv
// Node stores, cursor and result registers of the linked list core.
module odll_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  odll_pkg::req_t          in_req_type,
  input  logic signed [31:0]      in_key,
  input  logic signed [31:0]      in_anchor_key,
  input  odll_pkg::hnd_t          in_node_handle,
  input  odll_pkg::dp_cmd_t       dp_cmd,
  output odll_pkg::dp_stat_t      dp_stat,
  output odll_pkg::stat_t         out_status,
  output odll_pkg::hnd_t          out_result_node,
  output logic signed [31:0]      out_node_key,
  output odll_pkg::hnd_t          out_next_node,
  output odll_pkg::hnd_t          out_prev_node,
  output odll_pkg::hnd_t          out_entry_count
);
  import odll_pkg::*;

  logic signed [31:0] key_mem [POOL_SIZE];
  hnd_t               nxt_mem [POOL_SIZE];
  hnd_t               prv_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] valid_r;
  hnd_t first_r, last_r, count_r;

  req_t               req_r;
  logic signed [31:0] key_r, anc_r;
  hnd_t               hnd_r;
  hnd_t               cur_r;      // cursor / successor
  hnd_t               pre_r;      // predecessor
  hnd_t               new_r;      // allocated slot
  logic signed [31:0] rd_key_r;
  hnd_t               rd_nxt_r, rd_prv_r;

  stat_t              st_r;
  hnd_t               rn_r, nn_r, pn_r;
  logic signed [31:0] nk_r;

  function automatic logic is_node(hnd_t h, logic [POOL_SIZE-1:0] v);
    return (h < END_H) && v[h[IDX_W-1:0]];
  endfunction

  // Lowest free slot, combinational priority pick on the valid map.
  hnd_t free_slot;
  always_comb begin
    free_slot = END_H;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_slot = hnd_t'(i);
    end
  end

  logic signed [31:0] search_key;
  assign search_key = (req_r == REQ_INS_KEY) ? anc_r : key_r;

  assign dp_stat.cur_node = is_node(cur_r, valid_r);
  assign dp_stat.key_eq   = (rd_key_r == search_key);
  assign dp_stat.key_gt   = (rd_key_r > key_r);
  assign dp_stat.hnd_ok   = is_node(hnd_r, valid_r);
  assign dp_stat.hnd_end  = (hnd_r == END_H);
  assign dp_stat.full     = (free_slot == END_H);
  assign dp_stat.req      = req_r;

  idx_t cur_i, pre_i, new_i;
  assign cur_i = cur_r[IDX_W-1:0];
  assign pre_i = pre_r[IDX_W-1:0];
  assign new_i = new_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      first_r <= END_H;
      last_r  <= END_H;
      count_r <= '0;
    end else begin
      case (dp_cmd.cmd)
        CMD_LOAD: begin
          req_r <= in_req_type;
          key_r <= in_key;
          anc_r <= in_anchor_key;
          hnd_r <= in_node_handle;
          cur_r <= first_r;
          new_r <= free_slot;
        end
        CMD_RD_CUR: begin
          rd_key_r <= key_mem[cur_i];
          rd_nxt_r <= nxt_mem[cur_i];
          rd_prv_r <= prv_mem[cur_i];
        end
        CMD_STEP: cur_r <= rd_nxt_r;
        CMD_SEL_HND: cur_r <= (hnd_r == END_H && req_r == REQ_READ) ? first_r : hnd_r;
        CMD_SEL_PRE: begin
          if (!is_node(cur_r, valid_r)) cur_r <= END_H;
          pre_r <= is_node(cur_r, valid_r) ? rd_prv_r : last_r;
        end
        CMD_WR_NEW: begin
          key_mem[new_i] <= key_r;
          nxt_mem[new_i] <= cur_r;
          prv_mem[new_i] <= pre_r;
        end
        CMD_WR_PNEXT: begin
          if (is_node(pre_r, valid_r)) nxt_mem[pre_i] <= new_r;
          else first_r <= new_r;
        end
        CMD_WR_SPREV: begin
          if (is_node(cur_r, valid_r)) prv_mem[cur_i] <= new_r;
          else last_r <= new_r;
          valid_r[new_i] <= 1'b1;
          count_r <= count_r + hnd_t'(1);
          cur_r <= new_r;
        end
        CMD_UNL_P: begin
          pre_r <= cur_r;
          if (is_node(rd_prv_r, valid_r)) nxt_mem[rd_prv_r[IDX_W-1:0]] <= rd_nxt_r;
          else first_r <= rd_nxt_r;
        end
        CMD_UNL_X: begin
          if (is_node(rd_nxt_r, valid_r)) prv_mem[rd_nxt_r[IDX_W-1:0]] <= rd_prv_r;
          else last_r <= rd_prv_r;
          valid_r[cur_i] <= 1'b0;
          if (count_r != '0) count_r <= count_r - hnd_t'(1);
        end
        CMD_CLEAR: begin
          valid_r <= '0;
          first_r <= END_H;
          last_r  <= END_H;
          count_r <= '0;
        end
        CMD_REPORT: begin
          st_r <= dp_cmd.status;
          if (dp_cmd.use_node) begin
            rn_r <= cur_r;
            nk_r <= rd_key_r;
            nn_r <= rd_nxt_r;
            pn_r <= rd_prv_r;
          end else begin
            rn_r <= END_H;
            nk_r <= '0;
            nn_r <= END_H;
            pn_r <= END_H;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_status      = st_r;
  assign out_result_node = rn_r;
  assign out_node_key    = nk_r;
  assign out_next_node   = nn_r;
  assign out_prev_node   = pn_r;
  assign out_entry_count = count_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= END_H) else $error("node count above pool size");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.cmd == CMD_CLEAR |=> valid_r == '0 && count_r == '0)
    else $error("clear left nodes behind");
  a_ins_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.cmd == CMD_WR_SPREV |=> valid_r[$past(new_i)])
    else $error("inserted node not marked valid");
`endif
endmodule

// File: rtl/odll_ctrl.sv
// Request sequencer of the linked list core.
module odll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  odll_pkg::dp_stat_t dp_stat,
  output odll_pkg::dp_cmd_t  dp_cmd
);
  import odll_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_WREAD, S_WTEST, S_PRE, S_INS_CHK, S_WNEW, S_WPN, S_WSP,
    S_RPT_RD, S_DEL_P, S_DEL_X, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   [HND_W-1:0] steps_r, steps_nxt;
  logic   out_valid_r, out_valid_nxt;
  dp_cmd_t cmd;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign dp_cmd    = cmd;

  function automatic logic walks(req_t r);
    return r == REQ_INS_ORD || r == REQ_INS_KEY || r == REQ_DEL_KEY || r == REQ_FIND;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r;
    cmd           = '{cmd: CMD_NONE, status: ST_OK, use_node: 1'b0};
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.cmd = CMD_LOAD; steps_nxt = '0; state_nxt = S_DISP;
      end
      S_DISP: begin
        if (walks(dp_stat.req)) begin
          state_nxt = S_WREAD;
        end else if (dp_stat.req == REQ_CLEAR) begin
          cmd.cmd = CMD_CLEAR; state_nxt = S_RPT_RD;
        end else begin
          cmd.cmd = CMD_SEL_HND; state_nxt = S_RPT_RD;
          if (dp_stat.req == REQ_INS_HND) state_nxt = S_WREAD;
        end
      end
      S_WREAD: begin
        cmd.cmd = CMD_RD_CUR; state_nxt = S_WTEST;
      end
      S_WTEST: begin
        if (dp_stat.req == REQ_INS_HND) begin
          if (!dp_stat.hnd_ok && !dp_stat.hnd_end) begin
            cmd = '{cmd: CMD_REPORT, status: ST_BADHND, use_node: 1'b0};
            out_valid_nxt = 1'b1; state_nxt = S_OUT;
          end else begin
            state_nxt = S_PRE;
          end
        end else if (!dp_stat.cur_node || steps_r == END_H) begin
          if (dp_stat.req == REQ_INS_ORD) state_nxt = S_PRE;
          else begin
            cmd = '{cmd: CMD_REPORT, status: ST_NOTFOUND, use_node: 1'b0};
            out_valid_nxt = 1'b1; state_nxt = S_OUT;
          end
        end else if (dp_stat.req == REQ_INS_ORD ? dp_stat.key_gt : dp_stat.key_eq) begin
          if (dp_stat.req == REQ_DEL_KEY) state_nxt = S_DEL_P;
          else if (dp_stat.req == REQ_FIND) begin
            cmd = '{cmd: CMD_REPORT, status: ST_OK, use_node: 1'b1};
            out_valid_nxt = 1'b1; state_nxt = S_OUT;
          end else state_nxt = S_PRE;
        end else begin
          cmd.cmd = CMD_STEP; steps_nxt = steps_r + hnd_t'(1); state_nxt = S_WREAD;
        end
      end
      S_PRE: begin
        cmd.cmd = CMD_SEL_PRE; state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (dp_stat.full) begin
          cmd = '{cmd: CMD_REPORT, status: ST_FULL, use_node: 1'b0};
          out_valid_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.cmd = CMD_WR_NEW; state_nxt = S_WPN;
        end
      end
      S_WPN: begin cmd.cmd = CMD_WR_PNEXT; state_nxt = S_WSP; end
      S_WSP: begin cmd.cmd = CMD_WR_SPREV; state_nxt = S_RPT_RD; end
      S_RPT_RD: begin
        cmd.cmd = CMD_RD_CUR;
        state_nxt = (dp_stat.req == REQ_DEL_HND) ? S_DEL_P : S_DEL_X;
        if (dp_stat.req == REQ_DEL_HND && !dp_stat.hnd_ok) state_nxt = S_DEL_X;
      end
      S_DEL_P: begin
        // Result carries the links as they were before removal.
        cmd = '{cmd: CMD_REPORT, status: ST_OK, use_node: 1'b1};
        state_nxt = S_DEL_X;
        steps_nxt = '1;
      end
      S_DEL_X: begin
        if (steps_r == '1) begin
          cmd.cmd = CMD_UNL_P; steps_nxt = '0; state_nxt = S_DEL_X;
          state_nxt = S_OUT; out_valid_nxt = 1'b0;
        end else begin
          // Final report for all non-delete paths and for a delete with a bad handle.
          cmd.cmd = CMD_REPORT;
          cmd.use_node = dp_stat.cur_node;
          cmd.status = ST_OK;
          if ((dp_stat.req == REQ_DEL_HND) ||
              (dp_stat.req == REQ_READ && !dp_stat.hnd_end)) begin
            if (!dp_stat.hnd_ok) begin
              cmd.status = ST_BADHND; cmd.use_node = 1'b0;
            end
          end
          out_valid_nxt = 1'b1; state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r) begin
          cmd.cmd = CMD_UNL_X; out_valid_nxt = 1'b1;
        end else if (out_ready) begin
          out_valid_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accepting while a result waits");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WTEST |-> steps_r <= END_H) else $error("walk ran past pool");
`endif
endmodule

// File: rtl/ordered_doubly_linked_list_core.sv
// Top level of the ordered doubly linked list core.
// One transaction is in flight at a time; the walk's read-then-test loop
// over the link store sets the throughput.
// Reset (rst_n low, synchronous) empties the list; key and link stores hold
// no reset value and their contents are used only for valid nodes.
module ordered_doubly_linked_list_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  odll_pkg::req_t        in_req_type,
  input  logic signed [31:0]    in_key,
  input  logic signed [31:0]    in_anchor_key,
  input  odll_pkg::hnd_t        in_node_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output odll_pkg::stat_t       out_status,
  output odll_pkg::hnd_t        out_result_node,
  output logic signed [31:0]    out_node_key,
  output odll_pkg::hnd_t        out_next_node,
  output odll_pkg::hnd_t        out_prev_node,
  output odll_pkg::hnd_t        out_entry_count
);
  import odll_pkg::*;

  // The controller sequences each transaction; the datapath owns all storage.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  odll_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .dp_stat, .dp_cmd
  );

  odll_datapath u_dp (
    .clk, .rst_n, .in_req_type, .in_key, .in_anchor_key, .in_node_handle,
    .dp_cmd, .dp_stat, .out_status, .out_result_node, .out_node_key,
    .out_next_node, .out_prev_node, .out_entry_count
  );

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= END_H) else $error("bad entry count");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_node == END_H)
    else $error("error result names a node");
`endif
endmodule
